// ----- hdl/palette_sprite_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// palette_sprite_decoder assertion macros
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PALETTE_SPRITE_DECODER_MACROS_SVH
`define PALETTE_SPRITE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define PSD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PSD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, types and codes of the palette sprite decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int DIM_BITS      = 16;
  localparam int COLOR_W       = 24;
  localparam int ADDR_W        = 32;
  localparam int CFG_DATA_W    = 16;
  localparam int COUNT_W       = 9;

  // Palette depth at the width of entry_count, for range checks.
  localparam logic [COUNT_W-1:0] PAL_DEPTH_W = COUNT_W'(PALETTE_DEPTH);

  typedef logic [DIM_BITS-1:0] dim_t;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_COLUMN_ORDER = 2'd2,
    CFG_ENTRY_COUNT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        image_width;
    logic [15:0]        image_height;
    logic               column_order;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  // Walker status toward the pipeline: current pixel position and end mark.
  typedef struct packed {
    logic              last;
    logic [ADDR_W-1:0] address;
  } walk_t;

  typedef struct packed {
    logic              hit;
    logic              bad;
    logic              last;
    logic [ADDR_W-1:0] address;
  } pipe_t;

endpackage

// ----- hdl/psd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// psd_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface psd_cfg_if import psd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/psd_pix_in_if.sv -----
// ----------------------------------------------------------------------------
// psd_pix_in_if
// Input item channel: palette writes and pixel indexes.
// ----------------------------------------------------------------------------
interface psd_pix_in_if import psd_pkg::*; ();
  logic               valid;
  logic               ready;
  op_t                op;
  logic [7:0]         palette_slot;
  logic [COLOR_W-1:0] color;
  logic [7:0]         color_idx;

  modport source (output valid, op, palette_slot, color, color_idx, input ready);
  modport sink   (input valid, op, palette_slot, color, color_idx, output ready);
endinterface

// ----- hdl/psd_pix_out_if.sv -----
// ----------------------------------------------------------------------------
// psd_pix_out_if
// Result channel: decoded pixel color, address and flags.
// ----------------------------------------------------------------------------
interface psd_pix_out_if import psd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [ADDR_W-1:0]  pixel_address;
  logic               index_bad;
  logic               last_pixel;

  modport source (output valid, pixel_color, pixel_address, index_bad, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_color, pixel_address, index_bad, last_pixel,
                  output ready);
endinterface

// ----- hdl/psd_ram.sv -----
// ----------------------------------------------------------------------------
// psd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/psd_walker.sv -----
// ----------------------------------------------------------------------------
// psd_walker
// Pixel position counters and frame-buffer address of the next pixel.
// ----------------------------------------------------------------------------
module psd_walker import psd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  cfg_t  cfg,
  output walk_t walk
);

  dim_t inner;
  dim_t outer;
  dim_t pos_row;
  dim_t pos_col;
  dim_t pos_width;

  dim_t              w;
  dim_t              h;
  dim_t              inner_lim;
  dim_t              outer_lim;
  logic [DIM_BITS:0] inner_inc;
  logic [DIM_BITS:0] outer_inc;
  logic              inner_wrap;
  logic              last;
  dim_t              inner_next;
  dim_t              outer_next;
  logic [2*DIM_BITS-1:0] prod;

  assign w = cfg.image_width[DIM_BITS-1:0];
  assign h = cfg.image_height[DIM_BITS-1:0];

  always_comb begin
    inner_lim  = cfg.column_order ? h : w;
    outer_lim  = cfg.column_order ? w : h;
    inner_inc  = {1'b0, inner} + {{DIM_BITS{1'b0}}, 1'b1};
    outer_inc  = {1'b0, outer} + {{DIM_BITS{1'b0}}, 1'b1};
    // a counter past a shrunken limit wraps here as well
    inner_wrap = inner_inc >= {1'b0, inner_lim};
    last       = inner_wrap && (outer_inc >= {1'b0, outer_lim});
    inner_next = inner_wrap ? '0 : inner_inc[DIM_BITS-1:0];
    if (!inner_wrap) begin
      outer_next = outer;
    end else if (last) begin
      outer_next = '0;
    end else begin
      outer_next = outer_inc[DIM_BITS-1:0];
    end
  end

  // Position is latched with the width and order in force at the step, so a
  // later register write does not move the pending address.
  always_ff @(posedge clk) begin
    if (rst) begin
      inner     <= '0;
      outer     <= '0;
      pos_row   <= '0;
      pos_col   <= '0;
      pos_width <= '0;
    end else if (step) begin
      inner     <= inner_next;
      outer     <= outer_next;
      pos_row   <= cfg.column_order ? inner_next : outer_next;
      pos_col   <= cfg.column_order ? outer_next : inner_next;
      pos_width <= w;
    end
  end

  assign prod         = (2*DIM_BITS)'(pos_row) * (2*DIM_BITS)'(pos_width);
  assign walk.address = ADDR_W'(prod) + ADDR_W'(pos_col);
  assign walk.last    = last;

endmodule

// ----- hdl/palette_sprite_decoder.sv -----
// ----------------------------------------------------------------------------
// palette_sprite_decoder
// Indexed-color sprite decoder: palette RAM lookup plus frame-buffer walk.
// ----------------------------------------------------------------------------
//
//   channel    | dir | beat contents
//   -----------+-----+----------------------------------------------------
//   cfg        | in  | index, data (width, height, column order, count)
//   pixel_in   | in  | op, palette_slot, color, color_idx
//   pixel_out  | out | pixel_color, pixel_address, index_bad, last_pixel
//
// One input beat per cycle while input ready is high; a pixel result passes the read
// stage and then the output register. The rate is set by the single read port of the
// palette RAM and the registered counter update of the walker.
// Reset clears the palette at once through per-entry valid bits; no sweep.
// A stalled result holds in the output register while one more lookup waits
// in the read stage; input ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "palette_sprite_decoder_macros.svh"

module palette_sprite_decoder import psd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  psd_cfg_if.sink       cfg,
  psd_pix_in_if.sink    pixel_in,
  psd_pix_out_if.source pixel_out
);

  cfg_t cfg_regs;

  logic                     accept;
  logic                     is_pixel;
  logic                     dims_ok;
  logic                     count_pixel;
  logic                     pal_we;
  logic [COLOR_W-1:0]       pal_wdata;
  logic [PALETTE_DEPTH-1:0] pal_valid;
  logic                     ram_re;
  logic [COLOR_W-1:0]       ram_rdata;
  logic                     idx_bad;
  walk_t                    walk;

  logic  s1_valid;
  pipe_t s1;
  logic  s1_move;
  logic  out_valid;
  logic  bad_color;

  // ---------------- register writes ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.image_width  <= '0;
      cfg_regs.image_height <= '0;
      cfg_regs.column_order <= 1'b0;
      cfg_regs.entry_count  <= COUNT_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_IMAGE_WIDTH:  cfg_regs.image_width  <= cfg.data;
        CFG_IMAGE_HEIGHT: cfg_regs.image_height <= cfg.data;
        CFG_COLUMN_ORDER: cfg_regs.column_order <= cfg.data[0];
        CFG_ENTRY_COUNT:  cfg_regs.entry_count  <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input decode ----------------
  assign accept   = pixel_in.valid && pixel_in.ready;
  assign is_pixel = pixel_in.op == OP_PIXEL;
  assign dims_ok  = (|cfg_regs.image_width[DIM_BITS-1:0]) &&
                    (|cfg_regs.image_height[DIM_BITS-1:0]);

  // pixels are dropped while either dimension is zero
  assign count_pixel = accept && is_pixel && dims_ok;

  // slot zero stays transparent; a black write is kept visible as 1
  assign pal_we    = accept && !is_pixel && (pixel_in.palette_slot != '0) &&
                     ({1'b0, pixel_in.palette_slot} < PAL_DEPTH_W);
  assign pal_wdata = (pixel_in.color == '0) ? COLOR_W'(1) : pixel_in.color;

  assign idx_bad = ({1'b0, pixel_in.color_idx} >= cfg_regs.entry_count) ||
                   ({1'b0, pixel_in.color_idx} >= PAL_DEPTH_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (pal_we) begin
      pal_valid[pixel_in.palette_slot[PAL_AW-1:0]] <= 1'b1;
    end
  end

  // ---------------- palette store ----------------
  assign ram_re = count_pixel;

  psd_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pixel_in.palette_slot[PAL_AW-1:0]),
    .wdata (pal_wdata),
    .re    (ram_re),
    .raddr (pixel_in.color_idx[PAL_AW-1:0]),
    .rdata (ram_rdata)
  );

  psd_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .step (count_pixel),
    .cfg  (cfg_regs),
    .walk (walk)
  );

  // ---------------- read stage ----------------
  assign s1_move        = !out_valid || pixel_out.ready;
  assign pixel_in.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_in.ready) begin
      s1_valid <= count_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (count_pixel) begin
      s1.hit     <= !idx_bad && pal_valid[pixel_in.color_idx[PAL_AW-1:0]];
      s1.bad     <= idx_bad;
      s1.last    <= walk.last;
      s1.address <= walk.address;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      pixel_out.pixel_color   <= s1.hit ? ram_rdata : '0;
      pixel_out.pixel_address <= s1.address;
      pixel_out.index_bad     <= s1.bad;
      pixel_out.last_pixel    <= s1.last;
    end
  end

  assign pixel_out.valid = out_valid;

  assign bad_color = pixel_out.index_bad && (pixel_out.pixel_color != '0);

  // ---------------- assertions ----------------
  `PSD_ASSERT_IMPL(a_no_read_while_held, clk, rst, s1_valid && !s1_move, !ram_re, "held read")
  `PSD_ASSERT_NEXT(a_write_no_result, clk, rst, accept && !is_pixel, !s1_valid, "write lookup")
  `PSD_ASSERT_IMPL(a_bad_is_clear, clk, rst, out_valid, !bad_color, "bad index with color")
  `PSD_ASSERT_NEXT(a_stage_advance, clk, rst, s1_valid && s1_move, out_valid, "lookup lost")

endmodule
